// File: src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define WVP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define WVP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/wvp_pkg.sv
// Package for the waypoint velocity profile: widths, codes, payload and
// control structs. No dependencies.
`timescale 1ns / 1ps

package wvp_pkg;

    localparam int DIST_WIDTH  = 24;
    localparam int DIST_FRAC   = 8;
    localparam int SPEED_WIDTH = 16;
    localparam int ZONE_WIDTH  = 2;
    localparam int CFG_IDX_WIDTH = 2;

    // position fraction (Q0.16) and shape operand width
    localparam int FRAC_WIDTH  = 16;
    localparam int MUL_WIDTH   = FRAC_WIDTH + 1;
    localparam int SHAPE_SHIFT = FRAC_WIDTH - 2;

    // peak radicand floor(segment * 256 / 10) = (segment * RECIP_TEN) >> RECIP_SHIFT
    localparam int RECIP_WIDTH = 31;
    localparam logic [RECIP_WIDTH-1:0] RECIP_TEN = 31'h6666_6667;
    localparam int RECIP_SHIFT = 26;
    localparam int PROD_WIDTH  = DIST_WIDTH + RECIP_WIDTH;

    // shared divide / square root unit
    localparam int QUO_WIDTH  = DIST_WIDTH + DIST_FRAC;
    localparam int SQ_WIDTH   = 2 * ((QUO_WIDTH + 1) / 2);
    localparam int ROOT_WIDTH = SQ_WIDTH / 2;
    localparam int REM_WIDTH  = (DIST_WIDTH + 1 > ROOT_WIDTH + 3) ?
                                (DIST_WIDTH + 1) : (ROOT_WIDTH + 3);
    localparam int CNT_WIDTH  = $clog2(SQ_WIDTH + 1);

    localparam logic [DIST_WIDTH-1:0]  RADIUS_RESET    = DIST_WIDTH'(256);
    localparam logic [DIST_WIDTH-1:0]  BAND_RESET      = DIST_WIDTH'(1280);
    localparam logic [SPEED_WIDTH-1:0] MIN_SPEED_RESET = SPEED_WIDTH'(128);
    localparam logic [SPEED_WIDTH-1:0] PEAK_RESET      = SPEED_WIDTH'(256);

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_CAPTURE_RADIUS  = 2'd0,
        CFG_HYSTERESIS_BAND = 2'd1,
        CFG_MIN_SPEED       = 2'd2
    } cfg_idx_t;

    typedef enum logic [ZONE_WIDTH-1:0] {
        ZONE_NEAR    = 2'd0,
        ZONE_PROFILE = 2'd1,
        ZONE_HOLD    = 2'd2
    } zone_t;

    typedef enum logic {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } unit_op_t;

    typedef struct packed {
        logic [DIST_WIDTH-1:0] dist_from_last;
        logic [DIST_WIDTH-1:0] dist_to_next;
        logic [DIST_WIDTH-1:0] segment_length;
    } in_t;

    typedef struct packed {
        logic [SPEED_WIDTH-1:0] speed;
        logic [SPEED_WIDTH-1:0] peak_speed;
        logic [ZONE_WIDTH-1:0]  zone;
    } out_t;

    typedef struct packed {
        logic [DIST_WIDTH-1:0]  capture_radius;
        logic [DIST_WIDTH-1:0]  hysteresis_band;
        logic [SPEED_WIDTH-1:0] min_speed;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        unit_op_t              op;
        logic [REM_WIDTH-1:0]  rem_init;
        logic [SQ_WIDTH-1:0]   operand;
        logic [DIST_WIDTH-1:0] divisor;
        logic [CNT_WIDTH-1:0]  steps;
    } unit_cmd_t;

    typedef struct packed {
        logic                done;
        logic [SQ_WIDTH-1:0] result;
    } unit_rsp_t;

endpackage

// File: src/wvp_unit.sv
// Shared restoring divide / square root unit, one quotient or root bit per cycle.
// Depends on wvp_pkg.
`timescale 1ns / 1ps

module wvp_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  wvp_pkg::unit_cmd_t cmd,
    output wvp_pkg::unit_rsp_t rsp
);
    import wvp_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_WIDTH-1:0]  cnt_reg;
    unit_op_t              op_reg;
    logic [REM_WIDTH-1:0]  rem_reg;
    logic [SQ_WIDTH-1:0]   shift_reg;
    logic [SQ_WIDTH-1:0]   res_reg;
    logic [DIST_WIDTH-1:0] divisor_reg;

    logic [REM_WIDTH-1:0]  cand;
    logic [REM_WIDTH-1:0]  trial;
    logic [REM_WIDTH:0]    diff;
    logic                  take;
    logic [REM_WIDTH-1:0]  rem_next;
    logic [SQ_WIDTH-1:0]   shift_next;

    always_comb begin
        if (op_reg == OP_SQRT) begin
            cand       = {rem_reg[REM_WIDTH-3:0], shift_reg[SQ_WIDTH-1 -: 2]};
            trial      = {res_reg[REM_WIDTH-3:0], 2'b01};
            shift_next = {shift_reg[SQ_WIDTH-3:0], 2'b00};
        end else begin
            cand       = {rem_reg[REM_WIDTH-2:0], shift_reg[SQ_WIDTH-1]};
            trial      = {{(REM_WIDTH-DIST_WIDTH){1'b0}}, divisor_reg};
            shift_next = {shift_reg[SQ_WIDTH-2:0], 1'b0};
        end
        diff     = {1'b0, cand} - {1'b0, trial};
        take     = !diff[REM_WIDTH];
        rem_next = take ? diff[REM_WIDTH-1:0] : cand;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_WIDTH'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg      <= cmd.op;
            rem_reg     <= cmd.rem_init;
            shift_reg   <= cmd.operand;
            res_reg     <= '0;
            divisor_reg <= cmd.divisor;
        end else if (busy_reg) begin
            rem_reg   <= rem_next;
            shift_reg <= shift_next;
            res_reg   <= {res_reg[SQ_WIDTH-2:0], take};
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

// File: src/wvp_seq.sv
// Sequencer: zone choice, peak and position through the shared unit, shape
// multiply, clamping, speed state and output register. Depends on wvp_pkg.
`timescale 1ns / 1ps

module wvp_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wvp_pkg::in_t       s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output wvp_pkg::out_t      m_data,
    input  wvp_pkg::cfg_t      cfg,
    output wvp_pkg::unit_cmd_t ucmd,
    input  wvp_pkg::unit_rsp_t ursp
);
    import wvp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV10,
        S_ROOT,
        S_POS,
        S_POS_DIV,
        S_SHAPE,
        S_SCALE,
        S_SPEED,
        S_DONE
    } state_t;

    localparam logic [MUL_WIDTH-1:0] X_ONE = MUL_WIDTH'(1) << FRAC_WIDTH;

    state_t                 state_reg;
    logic                   m_valid_reg;
    out_t                   m_data_reg;
    unit_cmd_t              ucmd_reg;
    logic [SPEED_WIDTH-1:0] cur_speed_reg;
    logic [SPEED_WIDTH-1:0] peak_lim_reg;
    logic [ZONE_WIDTH-1:0]  zone_reg;
    logic [DIST_WIDTH-1:0]  dtn_reg;
    logic [DIST_WIDTH-1:0]  seg_reg;
    logic [MUL_WIDTH-1:0]   x_reg;
    logic [PROD_WIDTH-1:0]  prod_reg;
    logic [SPEED_WIDTH-1:0] vcand_reg;

    logic [DIST_WIDTH:0]    edge_dist;
    logic [DIST_WIDTH+1:0]  two_edge_dist;
    logic                   too_short;
    logic [DIST_WIDTH-1:0]  den;
    logic [DIST_WIDTH-1:0]  num;
    logic [DIST_WIDTH-1:0]  mul_a;
    logic [RECIP_WIDTH-1:0] mul_b;
    logic [PROD_WIDTH-1:0]  mul_p;
    logic                   start_next;
    logic [SPEED_WIDTH-1:0] root_sat;
    logic [SPEED_WIDTH-1:0] v_hi;
    logic [SPEED_WIDTH-1:0] v_out;
    logic                   accept;

    assign accept        = s_valid && s_ready;
    assign s_ready       = (state_reg == S_IDLE);
    assign edge_dist     = {1'b0, cfg.capture_radius} + {1'b0, cfg.hysteresis_band};
    assign two_edge_dist = {edge_dist, 1'b0};
    assign too_short     = ({2'b00, seg_reg} <= two_edge_dist) ||
                           ({1'b0, dtn_reg} <= edge_dist);
    assign den           = seg_reg - two_edge_dist[DIST_WIDTH-1:0];
    assign num           = dtn_reg - edge_dist[DIST_WIDTH-1:0];
    assign root_sat      = (|ursp.result[SQ_WIDTH-1:SPEED_WIDTH]) ?
                           {SPEED_WIDTH{1'b1}} : ursp.result[SPEED_WIDTH-1:0];
    assign v_hi          = (vcand_reg > peak_lim_reg) ? peak_lim_reg : vcand_reg;
    assign v_out         = (v_hi < cfg.min_speed) ? cfg.min_speed : v_hi;
    assign mul_p         = mul_a * mul_b;

    always_comb begin
        unique case (state_reg)
            S_DIV10: begin
                mul_a = seg_reg;
                mul_b = RECIP_TEN;
            end
            S_SHAPE: begin
                mul_a = DIST_WIDTH'(x_reg);
                mul_b = RECIP_WIDTH'(X_ONE - x_reg);
            end
            default: begin
                mul_a = DIST_WIDTH'({1'b0, peak_lim_reg - cfg.min_speed});
                mul_b = RECIP_WIDTH'(prod_reg[SHAPE_SHIFT +: MUL_WIDTH]);
            end
        endcase
    end

    always_comb begin
        unique case (state_reg)
            S_DIV10: start_next = 1'b1;
            S_POS:   start_next = !too_short && (num < den);
            default: start_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            ucmd_reg.start <= 1'b0;
            cur_speed_reg  <= '0;
            peak_lim_reg   <= PEAK_RESET;
        end else begin
            ucmd_reg.start <= start_next;
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        dtn_reg <= s_data.dist_to_next;
                        seg_reg <= s_data.segment_length;
                        if (s_data.dist_from_last < cfg.capture_radius) begin
                            zone_reg  <= ZONE_NEAR;
                            vcand_reg <= cfg.min_speed;
                            state_reg <= S_DONE;
                        end else if ({1'b0, s_data.dist_from_last} > edge_dist) begin
                            zone_reg  <= ZONE_PROFILE;
                            state_reg <= S_DIV10;
                        end else begin
                            zone_reg  <= ZONE_HOLD;
                            vcand_reg <= cur_speed_reg;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DIV10: begin
                    ucmd_reg.op       <= OP_SQRT;
                    ucmd_reg.rem_init <= '0;
                    ucmd_reg.operand  <= SQ_WIDTH'(mul_p >> RECIP_SHIFT);
                    ucmd_reg.steps    <= CNT_WIDTH'(ROOT_WIDTH);
                    state_reg         <= S_ROOT;
                end
                S_ROOT: begin
                    if (ursp.done) begin
                        peak_lim_reg <= root_sat;
                        state_reg    <= S_POS;
                    end
                end
                S_POS: begin
                    if (too_short) begin
                        x_reg     <= '0;
                        state_reg <= S_SHAPE;
                    end else if (num >= den) begin
                        x_reg     <= X_ONE;
                        state_reg <= S_SHAPE;
                    end else begin
                        ucmd_reg.op       <= OP_DIV;
                        ucmd_reg.rem_init <= REM_WIDTH'(num);
                        ucmd_reg.operand  <= '0;
                        ucmd_reg.divisor  <= den;
                        ucmd_reg.steps    <= CNT_WIDTH'(FRAC_WIDTH);
                        state_reg         <= S_POS_DIV;
                    end
                end
                S_POS_DIV: begin
                    if (ursp.done) begin
                        x_reg     <= {1'b0, ursp.result[FRAC_WIDTH-1:0]};
                        state_reg <= S_SHAPE;
                    end
                end
                S_SHAPE: begin
                    prod_reg  <= mul_p;
                    state_reg <= S_SCALE;
                end
                S_SCALE: begin
                    prod_reg  <= mul_p;
                    state_reg <= S_SPEED;
                end
                S_SPEED: begin
                    if (peak_lim_reg > cfg.min_speed) begin
                        vcand_reg <= cfg.min_speed + prod_reg[FRAC_WIDTH +: SPEED_WIDTH];
                    end else begin
                        vcand_reg <= cfg.min_speed;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.speed      <= v_out;
                        m_data_reg.peak_speed <= peak_lim_reg;
                        m_data_reg.zone       <= zone_reg;
                        cur_speed_reg         <= v_out;
                        state_reg             <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign ucmd    = ucmd_reg;

endmodule

// File: src/waypoint_velocity_profile.sv
// Top level of the waypoint velocity profile: configuration registers,
// sequencer and shared divide / square root unit. Depends on wvp_pkg.
//
//   port group   dir   handshake          payload
//   s_*          in    s_valid/s_ready    in_t  (three Q16.8 distances)
//   m_*          out   m_valid/m_ready    out_t (speed, peak_speed, zone)
//   cfg_*        in    cfg_we             cfg_idx, cfg_wdata
//
// Near and hold zones: an accepted item goes straight to S_DONE, which registers it.
// Profile zone: S_DIV10, S_ROOT, S_POS, S_POS_DIV when the position needs the divide,
// S_SHAPE, S_SCALE, S_SPEED, S_DONE; unit steps: 16 for the square root, 16 for the divide.
// One transaction at a time; s_ready is high only while the sequencer is idle. A
// result waiting on m_ready holds the next transaction in its last state.
// Reset (aresetn low, synchronous) restores register defaults and speed state.
`timescale 1ns / 1ps

module waypoint_velocity_profile (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  wvp_pkg::in_t                         s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output wvp_pkg::out_t                        m_data,
    input  logic                                 cfg_we,
    input  logic [wvp_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx,
    input  logic [wvp_pkg::DIST_WIDTH-1:0]       cfg_wdata
);
    import wvp_pkg::*;

    cfg_t      cfg_reg;
    unit_cmd_t ucmd;
    unit_rsp_t ursp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.capture_radius  <= RADIUS_RESET;
            cfg_reg.hysteresis_band <= BAND_RESET;
            cfg_reg.min_speed       <= MIN_SPEED_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_CAPTURE_RADIUS:  cfg_reg.capture_radius  <= cfg_wdata;
                CFG_HYSTERESIS_BAND: cfg_reg.hysteresis_band <= cfg_wdata;
                CFG_MIN_SPEED:       cfg_reg.min_speed       <= cfg_wdata[SPEED_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    wvp_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cfg     (cfg_reg),
        .ucmd    (ucmd),
        .ursp    (ursp)
    );

    wvp_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ucmd),
        .rsp     (ursp)
    );

endmodule

// File: src/wvp_checker.sv
// Port-level checks for waypoint_velocity_profile, attached by bind.
// Depends on wvp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wvp_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input wvp_pkg::out_t m_data
);

    // held result stays put until taken
    `WVP_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")

    // one transaction in flight: input closes right after acceptance
    `WVP_ASSERT(a_in_single, aclk, aresetn, s_valid && s_ready |=> !s_ready, "input stayed open after acceptance")

    // no result appears in the cycle right after acceptance
    `WVP_ASSERT(a_no_early_out, aclk, aresetn, s_valid && s_ready |=> !$rose(m_valid), "result too early")

    // reset leaves the block idle with an empty output
    `WVP_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid && s_ready, "not idle after reset")

endmodule

bind waypoint_velocity_profile wvp_checker u_wvp_checker (.*);

// File: test/waypoint_velocity_profile_test.sv
// Testbench for waypoint_velocity_profile: a directed set, then random phases across
// several register settings. Results are checked against an in-bench speed predictor.
// Depends on wvp_pkg and the waypoint_velocity_profile RTL.
`timescale 1ns / 1ps

module waypoint_velocity_profile_test;
    import wvp_pkg::*;

    localparam longint unsigned DIST_MAX = (64'd1 << DIST_WIDTH) - 1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_IDX = 2'd3;
    localparam int HOLD_CYCLES = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_idx = '0;
    logic [DIST_WIDTH-1:0] cfg_wdata = '0;

    // predictor copy of the block's registers and speed state
    logic [DIST_WIDTH-1:0] radius_reg;
    logic [DIST_WIDTH-1:0] band_reg;
    logic [SPEED_WIDTH-1:0] min_reg;
    logic [SPEED_WIDTH-1:0] cur_speed;
    logic [SPEED_WIDTH-1:0] peak_lim;

    in_t pending_items[$];
    out_t speed_cmds_due[$];
    int issued_cnt = 0;
    int accepted_cnt = 0;
    int results_seen = 0;
    int mismatches = 0;
    int settings_cnt = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic in_fire = 1'b0;
    bit hold_go = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;

    waypoint_velocity_profile dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root = 0;
        longint unsigned probe = 64'd1 << 62;
        while (probe > v)
            probe >>= 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v -= root + probe;
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic out_t compute_speed_cmd(in_t item);
        longint unsigned from_last, to_next, seg, rim, v, pk, x, f, den, num;
        zone_t zone;
        out_t res;
        from_last = item.dist_from_last;
        to_next = item.dist_to_next;
        seg = item.segment_length;
        rim = longint'(radius_reg) + longint'(band_reg);
        v = cur_speed;
        if (from_last < radius_reg) begin
            zone = ZONE_NEAR;
            v = min_reg;
        end else if (from_last > rim) begin
            zone = ZONE_PROFILE;
            pk = floor_sqrt((seg * 256) / 10);
            if (pk > 65535)
                pk = 65535;
            peak_lim = pk[SPEED_WIDTH-1:0];
            if (seg <= 2 * rim || to_next <= rim) begin
                x = 0;
            end else begin
                den = seg - 2 * rim;
                num = to_next - rim;
                x = (num >= den) ? 65536 : (num << 16) / den;
            end
            f = (4 * x * (65536 - x)) >> 16;
            if (peak_lim > min_reg)
                v = longint'(min_reg) + (((longint'(peak_lim) - longint'(min_reg)) * f) >> 16);
            else
                v = min_reg;
        end else begin
            zone = ZONE_HOLD;
        end
        if (v > peak_lim)
            v = peak_lim;
        if (v < min_reg)
            v = min_reg;
        cur_speed = v[SPEED_WIDTH-1:0];
        res.speed = cur_speed;
        res.peak_speed = peak_lim;
        res.zone = zone;
        return res;
    endfunction

    // predictor, register mirror and result checks
    always @(posedge aclk) begin : monitor
        out_t want;
        if (!aresetn) begin
            radius_reg = RADIUS_RESET;
            band_reg = BAND_RESET;
            min_reg = MIN_SPEED_RESET;
            cur_speed = '0;
            peak_lim = PEAK_RESET;
            speed_cmds_due.delete();
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_CAPTURE_RADIUS: radius_reg = cfg_wdata;
                    CFG_HYSTERESIS_BAND: band_reg = cfg_wdata;
                    CFG_MIN_SPEED: min_reg = cfg_wdata[SPEED_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (speed_cmds_due.size() == 0) begin
                    $error("result transaction with none expected: speed %0d peak %0d zone %0d",
                           m_data.speed, m_data.peak_speed, m_data.zone);
                    mismatches++;
                end else begin
                    want = speed_cmds_due.pop_front();
                    if (m_data.speed !== want.speed) begin
                        $error("speed: expected %0d, got %0d", want.speed, m_data.speed);
                        mismatches++;
                    end
                    if (m_data.peak_speed !== want.peak_speed) begin
                        $error("peak_speed: expected %0d, got %0d",
                               want.peak_speed, m_data.peak_speed);
                        mismatches++;
                    end
                    if (m_data.zone !== want.zone) begin
                        $error("zone: expected %0d, got %0d", want.zone, m_data.zone);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                speed_cmds_due.push_back(compute_speed_cmd(s_data));
                accepted_cnt++;
            end
        end
    end

    always @(negedge aclk) begin : driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= pending_items.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : receiver
        if (hold_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic longint unsigned clip_dist(longint unsigned v);
        return (v > DIST_MAX) ? DIST_MAX : v;
    endfunction

    function automatic longint unsigned pick_between(longint unsigned lo, longint unsigned hi);
        return lo + $urandom_range(32'(hi - lo));
    endfunction

    // random distance with a random magnitude
    function automatic longint unsigned spread_dist();
        return longint'($urandom() & 32'hFFFFFF) >> $urandom_range(DIST_WIDTH - 1);
    endfunction

    function automatic in_t draw_item();
        longint unsigned rim, seg, den;
        int unsigned pick;
        in_t it;
        rim = longint'(radius_reg) + longint'(band_reg);
        pick = $urandom_range(99);
        it.dist_from_last = DIST_WIDTH'($urandom());
        it.dist_to_next = DIST_WIDTH'($urandom());
        it.segment_length = DIST_WIDTH'($urandom());
        if (pick < 15)
            return it;
        it.segment_length = DIST_WIDTH'(spread_dist());
        if (pick < 35) begin
            if (radius_reg != 0)
                it.dist_from_last = DIST_WIDTH'(pick_between(0, radius_reg - 1));
            return it;
        end
        if (pick < 55) begin
            it.dist_from_last = DIST_WIDTH'(pick_between(radius_reg, clip_dist(rim)));
            return it;
        end
        if (rim >= DIST_MAX)
            return it;
        it.dist_from_last = DIST_WIDTH'(pick_between(rim + 1, DIST_MAX));
        if ($urandom_range(4) == 0 || 2 * rim + 1 > DIST_MAX)
            seg = pick_between(0, clip_dist(2 * rim));
        else
            seg = clip_dist(2 * rim + 1 + spread_dist());
        it.segment_length = DIST_WIDTH'(seg);
        if (seg <= 2 * rim)
            return it;
        den = seg - 2 * rim;
        pick = $urandom_range(99);
        if (pick < 15)
            it.dist_to_next = DIST_WIDTH'(pick_between(0, rim));
        else if (pick < 30)
            it.dist_to_next = DIST_WIDTH'(clip_dist(rim + den + $urandom_range(3)));
        else
            it.dist_to_next = DIST_WIDTH'(clip_dist(rim + pick_between(1, den - 1)));
        return it;
    endfunction

    task automatic queue_item(longint unsigned from_last, longint unsigned to_next,
                              longint unsigned seg);
        in_t it;
        it.dist_from_last = DIST_WIDTH'(from_last);
        it.dist_to_next = DIST_WIDTH'(to_next);
        it.segment_length = DIST_WIDTH'(seg);
        pending_items.push_back(it);
        issued_cnt++;
    endtask

    task automatic drain();
        while (accepted_cnt != issued_cnt || speed_cmds_due.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [DIST_WIDTH-1:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_regs(longint unsigned radius, longint unsigned band,
                                longint unsigned min_spd);
        write_reg(CFG_CAPTURE_RADIUS, DIST_WIDTH'(radius));
        write_reg(CFG_HYSTERESIS_BAND, DIST_WIDTH'(band));
        write_reg(CFG_MIN_SPEED, DIST_WIDTH'(min_spd));
        settings_cnt++;
    endtask

    task automatic run_phase(int n, int send_pct, int recv_pct, bit with_hold);
        @(posedge aclk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        hold_go = with_hold;
        repeat (n)
            pending_items.push_back(draw_item());
        issued_cnt += n;
        drain();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: radius 256, band 1280, rim at 1536
        @(posedge aclk);
        settings_cnt = 1;
        queue_item(0, 0, 0);
        queue_item(255, 0, 0);
        queue_item(256, 0, 0);
        queue_item(1536, 0, 0);
        queue_item(1537, 0, 0);
        queue_item(1537, 2000, 3072);
        queue_item(2000, 1536, 100000);
        queue_item(2000, 1536 + 96928, 100000);
        queue_item(2000, 1536 + 48464, 100000);
        queue_item(2000, 1536 + 24232, 100000);
        queue_item(1000, 5, 7);
        queue_item(100, 0, 0);
        queue_item(1000, 0, 0);
        queue_item(DIST_MAX, DIST_MAX, DIST_MAX);
        queue_item(DIST_MAX, 24'h800000, DIST_MAX);
        queue_item(DIST_MAX, 0, DIST_MAX);
        queue_item(1537, 1537, 3073);
        queue_item(1537, 1537, 3074);
        queue_item(DIST_MAX, 1600, 4000);
        drain();

        program_regs(512, 2048, 64);
        run_phase(80, 0, 0, 1'b0);
        program_regs(0, 0, 0);
        run_phase(50, 46, 0, 1'b0);
        program_regs(DIST_MAX, DIST_MAX, 16'hFFFF);
        run_phase(20, 0, 46, 1'b0);

        // upper bits of a speed write are dropped; the spare index is ignored
        program_regs(100, 50, 24'hA50180);
        write_reg(CFG_SPARE_IDX, 24'h000010);
        run_phase(80, 0, 46, 1'b0);
        program_regs(1024, 0, 16'h3000);
        run_phase(70, 9, 9, 1'b0);
        program_regs(300, 700, 200);
        run_phase(60, 0, 0, 1'b1);
        program_regs(40, 20000, 1);
        run_phase(80, 46, 0, 1'b0);

        repeat (100) @(posedge aclk);
        $display("Checked %0d results from %0d transactions under %0d register settings,",
                 results_seen, accepted_cnt, settings_cnt);
        $display("with sender gaps, receiver stalls and one long output hold-off.");
        if (mismatches == 0 && speed_cmds_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
